FILE: hw/rtl/apcs_pkg.sv
// ----------------------------------------------------------------------------
// apcs_pkg: shared types and constants of the audio clock prescaler search
// Widths of the request and result fields, reciprocal constants for the
// divide-by-constant steps, and the item that walks down the cell chain.
// ----------------------------------------------------------------------------
package apcs_pkg;

  localparam int unsigned ClkW  = 31;
  localparam int unsigned RateW = 20;
  localparam int unsigned ErrW  = 16;
  localparam int unsigned PsW   = 5;

  // Base rates are at most (2^31 - 1) / 256, which fits in 23 bits.
  localparam int unsigned BaseW = 23;

  // Exact floor(n / d) for 23-bit n and d up to 64:
  // q = (n * ceil(2^29 / d)) >> 29.
  localparam int unsigned RecipShift = BaseW + 6;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = BaseW + RecipW;

  // Exact floor(m / 3) for 24-bit m: (m * ceil(2^26 / 3)) >> 26.
  localparam int unsigned Div3InW   = 24;
  localparam int unsigned Div3Shift = 26;
  localparam int unsigned Div3W     = 25;
  localparam logic [Div3W-1:0] Div3Recip = 25'd22369622;

  localparam logic [ErrW-1:0] ErrLimit = 16'hFFFF;

  localparam int unsigned DividerCountDef = 32;

  // Everything that travels with a request down the chain.
  typedef struct packed {
    logic [BaseW-1:0] base256;
    logic [BaseW-1:0] base384;
    logic [RateW-1:0] rate;
    logic [ErrW-1:0]  err256;
    logic [PsW-1:0]   ps256;
    logic [ErrW-1:0]  err384;
    logic [PsW-1:0]   ps384;
  } apcs_item_t;

  // Shared stage control: advance enable and incoming request valid.
  typedef struct packed {
    logic enable;
    logic valid;
  } apcs_ctrl_t;

endpackage

FILE: hw/rtl/apcs_prep.sv
// ----------------------------------------------------------------------------
// apcs_prep: base rate stage
// Forms clock/256 and clock/384 and seeds the running best errors.
// ----------------------------------------------------------------------------
module apcs_prep import apcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  apcs_ctrl_t       ctrl_i,
  input  logic [ClkW-1:0]  clock_hz_i,
  input  logic [RateW-1:0] wanted_rate_i,
  output logic             valid_o,
  output apcs_item_t       item_o
);

  logic [Div3InW+Div3W-1:0] prod3;
  apcs_item_t               item_d;
  apcs_item_t               item_q;
  logic                     valid_q;

  // clock/384 is (clock/128)/3.
  assign prod3 = (Div3InW+Div3W)'(clock_hz_i[ClkW-1:ClkW-Div3InW])
               * (Div3InW+Div3W)'(Div3Recip);

  always_comb begin
    item_d         = '0;
    item_d.base256 = clock_hz_i[ClkW-1:ClkW-BaseW];
    item_d.base384 = prod3[Div3Shift+BaseW-1:Div3Shift];
    item_d.rate    = wanted_rate_i;
    item_d.err256  = ErrLimit;
    item_d.err384  = ErrLimit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.enable) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/apcs_cell.sv
// ----------------------------------------------------------------------------
// apcs_cell: one divider of the search chain
// Divides both base rates by its divider, then updates the running best
// error and prescaler of each mode when the new error is strictly smaller.
// ----------------------------------------------------------------------------
module apcs_cell import apcs_pkg::*; #(
  parameter int unsigned Div = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  apcs_ctrl_t ctrl_i,
  input  apcs_item_t item_i,
  output logic       valid_o,
  output apcs_item_t item_o
);

  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(Div) - 64'd1) / 64'(Div));
  localparam logic [PsW-1:0] Ps = PsW'(Div - 1);

  logic [ProdW-1:0] prod256;
  logic [ProdW-1:0] prod384;
  logic [BaseW-1:0] q256_q;
  logic [BaseW-1:0] q384_q;
  apcs_item_t       mid_q;
  logic             mid_valid_q;
  apcs_item_t       item_d;
  apcs_item_t       item_q;
  logic             valid_q;
  logic [BaseW-1:0] diff256;
  logic [BaseW-1:0] diff384;
  logic [BaseW-1:0] rate_ext;

  assign prod256 = ProdW'(item_i.base256) * ProdW'(Recip);
  assign prod384 = ProdW'(item_i.base384) * ProdW'(Recip);

  // Stage one: quotients.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      q256_q <= prod256[RecipShift+BaseW-1:RecipShift];
      q384_q <= prod384[RecipShift+BaseW-1:RecipShift];
      mid_q  <= item_i;
    end
  end

  // Stage two: absolute errors against the wanted rate.
  assign rate_ext = BaseW'(mid_q.rate);
  assign diff256  = (rate_ext >= q256_q) ? rate_ext - q256_q : q256_q - rate_ext;
  assign diff384  = (rate_ext >= q384_q) ? rate_ext - q384_q : q384_q - rate_ext;

  always_comb begin
    item_d = mid_q;
    if (diff256 < BaseW'(mid_q.err256)) begin
      item_d.err256 = diff256[ErrW-1:0];
      item_d.ps256  = Ps;
    end
    if (diff384 < BaseW'(mid_q.err384)) begin
      item_d.err384 = diff384[ErrW-1:0];
      item_d.ps384  = Ps;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (ctrl_i.enable) begin
      mid_valid_q <= ctrl_i.valid;
      valid_q     <= mid_valid_q;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/apcs_select.sv
// ----------------------------------------------------------------------------
// apcs_select: mode choice and result register
// Picks 384fs only when its error is strictly smaller; flags no match.
// ----------------------------------------------------------------------------
module apcs_select import apcs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  apcs_ctrl_t      ctrl_i,
  input  apcs_item_t      item_i,
  output logic            valid_o,
  output logic            use_384fs_o,
  output logic [PsW-1:0]  prescaler_o,
  output logic [ErrW-1:0] best_error_o,
  output logic            no_match_o
);

  logic            valid_q;
  logic            use_384fs_d, use_384fs_q;
  logic [PsW-1:0]  prescaler_d, prescaler_q;
  logic [ErrW-1:0] best_error_d, best_error_q;
  logic            no_match_d, no_match_q;

  always_comb begin
    use_384fs_d  = 1'b0;
    prescaler_d  = '0;
    best_error_d = ErrLimit;
    no_match_d   = 1'b0;
    if ((item_i.err256 == ErrLimit) && (item_i.err384 == ErrLimit)) begin
      no_match_d = 1'b1;
    end else if (item_i.err256 > item_i.err384) begin
      use_384fs_d  = 1'b1;
      prescaler_d  = item_i.ps384;
      best_error_d = item_i.err384;
    end else begin
      prescaler_d  = item_i.ps256;
      best_error_d = item_i.err256;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.enable) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      use_384fs_q  <= use_384fs_d;
      prescaler_q  <= prescaler_d;
      best_error_q <= best_error_d;
      no_match_q   <= no_match_d;
    end
  end

  assign valid_o      = valid_q;
  assign use_384fs_o  = use_384fs_q;
  assign prescaler_o  = prescaler_q;
  assign best_error_o = best_error_q;
  assign no_match_o   = no_match_q;

endmodule

FILE: hw/rtl/audio_clock_prescaler_search_top.sv
// A request passes the front stage, every cell, then the result register.
// Throughput: one request per cycle while the chain advances; each divider
// cell holds two pipeline stages (divide, then compare).
// The whole chain advances together and freezes only while a result is held.
// Reset clears every valid bit at once; payload registers are not reset.
// ----------------------------------------------------------------------------
// audio_clock_prescaler_search_top: best I2S prescaler for a sample rate
// A request carries a peripheral clock and a wanted sample rate. The front
// stage forms the 256fs and 384fs base rates, a chain of DIVIDER_COUNT cells
// tries dividers 1 upward, and the last stage picks the mode and registers
// the result.
// ----------------------------------------------------------------------------
module audio_clock_prescaler_search_top import apcs_pkg::*; #(
  parameter int unsigned DIVIDER_COUNT = DividerCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ClkW-1:0]  clock_hz_i,
  input  logic [RateW-1:0] wanted_rate_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             use_384fs_o,
  output logic [PsW-1:0]   prescaler_o,
  output logic [ErrW-1:0]  best_error_o,
  output logic             no_match_o
);

  // One shared advance enable: the chain moves unless the result register
  // holds a result that the receiver is stalling.
  logic                     enable;
  logic                     out_valid;
  logic [DIVIDER_COUNT:0]   chain_valid;
  apcs_item_t               chain_item [DIVIDER_COUNT+1];

  assign enable     = !out_valid || !out_stall_i;
  assign in_stall_o = !enable;

  apcs_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        ('{enable: enable, valid: in_valid_i}),
    .clock_hz_i    (clock_hz_i),
    .wanted_rate_i (wanted_rate_i),
    .valid_o       (chain_valid[0]),
    .item_o        (chain_item[0])
  );

  // Cell k tries divider k + 1 and hands its running best to cell k + 1.
  for (genvar k = 0; k < DIVIDER_COUNT; k++) begin : g_cell
    apcs_cell #(
      .Div (k + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  ('{enable: enable, valid: chain_valid[k]}),
      .item_i  (chain_item[k]),
      .valid_o (chain_valid[k+1]),
      .item_o  (chain_item[k+1])
    );
  end

  apcs_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       ('{enable: enable, valid: chain_valid[DIVIDER_COUNT]}),
    .item_i       (chain_item[DIVIDER_COUNT]),
    .valid_o      (out_valid),
    .use_384fs_o  (use_384fs_o),
    .prescaler_o  (prescaler_o),
    .best_error_o (best_error_o),
    .no_match_o   (no_match_o)
  );

  assign out_valid_o = out_valid;

  // A no-match result carries the fixed fallback fields.
  a_no_match_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && no_match_o) |->
      (best_error_o == ErrLimit && prescaler_o == '0 && !use_384fs_o))
    else $error("no-match result with non-default fields");

  // A matched result always has an error below the limit.
  a_match_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !no_match_o) |-> (best_error_o != ErrLimit))
    else $error("matched result reports limit error");

  // While the chain is frozen, no request moves or vanishes inside it.
  a_frozen_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable |=> $stable(chain_valid))
    else $error("chain valid bits changed while frozen");

  // The input is stalled exactly when a held result is being stalled.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid && out_stall_i))
    else $error("input stall does not follow the held result");

endmodule

FILE: tb/tb_audio_clock_prescaler_search_top.sv
// ----------------------------------------------------------------------------
// tb_audio_clock_prescaler_search_top: self-checking bench for the prescaler search
// Requests of peripheral clock and wanted sample rate go in through a queued
// driver. Each accepted request is scored by an independent search over both
// master-clock modes. A monitor compares every result field against the oldest
// prediction while both handshakes idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------
module tb_audio_clock_prescaler_search_top;
  import apcs_pkg::*;

  // The bench runs the block at its default divider count and predicts with
  // the same count, so both sides search the same range of dividers.
  localparam int unsigned NumDividers   = DividerCountDef;
  // Registers on the request-to-result path: front, two per cell, result.
  localparam int unsigned PipeLatency   = 2 * NumDividers + 2;
  // After the last prediction is retired, wait this long for stray results.
  localparam int unsigned DrainCycles   = 2 * PipeLatency;
  // Cycles with no handshake on either side before the run is abandoned.
  // Stall streaks at 80 percent and the pipeline latency stay far below it.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPerPhase = 160;
  localparam int unsigned RateMax = (1 << RateW) - 1;

  // One request as queued for the driver.
  typedef struct packed {
    logic [ClkW-1:0]  clock_hz;
    logic [RateW-1:0] rate;
  } rate_request_t;

  // The setting the block is expected to report for one request.
  typedef struct packed {
    logic            use_384fs;
    logic [PsW-1:0]  prescaler;
    logic [ErrW-1:0] best_error;
    logic            no_match;
  } clock_setting_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ClkW-1:0]  clock_hz_i = '0;
  logic [RateW-1:0] wanted_rate_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             use_384fs_o;
  logic [PsW-1:0]   prescaler_o;
  logic [ErrW-1:0]  best_error_o;
  logic             no_match_o;

  rate_request_t  request_queue[$];
  clock_setting_t predicted_settings[$];
  int unsigned    mismatch_count = 0;
  int unsigned    quiet_cycles = 0;
  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned    send_gap_pct = 0;
  int unsigned    stall_pct = 0;

  audio_clock_prescaler_search_top #(
    .DIVIDER_COUNT(NumDividers)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .clock_hz_i   (clock_hz_i),
    .wanted_rate_i(wanted_rate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .use_384fs_o  (use_384fs_o),
    .prescaler_o  (prescaler_o),
    .best_error_o (best_error_o),
    .no_match_o   (no_match_o)
  );

  always #6 clk_i = ~clk_i;

  // Searches both base rates, clock/256 and clock/384, over every divider and
  // keeps the first divider with the smallest error below the error limit.
  // The 384fs mode must beat 256fs strictly, so equal errors stay at 256fs.
  function automatic clock_setting_t best_prescaler(logic [ClkW-1:0] clk_hz,
                                                    logic [RateW-1:0] rate);
    longint unsigned base_rate [2];
    longint unsigned err_best [2];
    longint unsigned ps_best [2];
    bit              found [2];
    longint unsigned quotient;
    longint unsigned err;
    clock_setting_t  setting;
    base_rate[0] = longint'(clk_hz) / 256;
    base_rate[1] = longint'(clk_hz) / 384;
    for (int m = 0; m < 2; m++) begin
      err_best[m] = ErrLimit;
      ps_best[m]  = 0;
      found[m]    = 1'b0;
      for (int d = 1; d <= NumDividers; d++) begin
        quotient = base_rate[m] / d;
        err = (rate >= quotient) ? rate - quotient : quotient - rate;
        if (err < err_best[m]) begin
          err_best[m] = err;
          ps_best[m]  = d - 1;
          found[m]    = 1'b1;
        end
      end
    end
    if (!found[0] && !found[1]) begin
      setting = '{use_384fs: 1'b0, prescaler: '0, best_error: ErrLimit, no_match: 1'b1};
    end else if (err_best[0] > err_best[1]) begin
      setting = '{use_384fs: 1'b1, prescaler: ps_best[1][PsW-1:0],
                  best_error: err_best[1][ErrW-1:0], no_match: 1'b0};
    end else begin
      setting = '{use_384fs: 1'b0, prescaler: ps_best[0][PsW-1:0],
                  best_error: err_best[0][ErrW-1:0], no_match: 1'b0};
    end
    return setting;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic queue_request(logic [ClkW-1:0] clk_hz, logic [RateW-1:0] rate);
    request_queue.push_back('{clock_hz: clk_hz, rate: rate});
  endtask

  // Blocks until every queued request is accepted and every result has come.
  // Sampling on the falling edge keeps clear of the updates at the rising one.
  task automatic wait_until_drained();
    while (request_queue.size() != 0 || in_valid_i || predicted_settings.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: a request is taken at an edge where valid is high and stall is
  // low. The prediction is made at that same edge from the payload that was
  // on the pins. A new payload is presented only when the old one is gone
  // or none was offered, so a stalled request never changes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      clock_hz_i    <= '0;
      wanted_rate_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_settings.push_back(best_prescaler(clock_hz_i, wanted_rate_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          rate_request_t req;
          req = request_queue.pop_front();
          in_valid_i    <= 1'b1;
          clock_hz_i    <= req.clock_hz;
          wanted_rate_i <= req.rate;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: each accepted result is held against the oldest prediction,
  // field by field. The receiver stall is redrawn every cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_settings.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          clock_setting_t want;
          want = predicted_settings.pop_front();
          if (use_384fs_o !== want.use_384fs)
            report_mismatch($sformatf("use_384fs got %b, expected %b",
                                      use_384fs_o, want.use_384fs));
          if (prescaler_o !== want.prescaler)
            report_mismatch($sformatf("prescaler got %0d, expected %0d",
                                      prescaler_o, want.prescaler));
          if (best_error_o !== want.best_error)
            report_mismatch($sformatf("best_error got %0d, expected %0d",
                                      best_error_o, want.best_error));
          if (no_match_o !== want.no_match)
            report_mismatch($sformatf("no_match got %b, expected %b",
                                      no_match_o, want.no_match));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [ClkW-1:0] clk_v;
    longint          target;
    longint          span;
    int unsigned     kind;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests, no idling on either side.
    // Zero clock: every base is zero, so the error is the rate itself.
    queue_request('0, '0);
    queue_request('0, RateW'(65534));
    // Zero clock with a rate at the error limit or above gives no match.
    queue_request('0, RateW'(65535));
    queue_request('0, RateW'(RateMax));
    // Largest clock and rate: clock/256 divided by 8 hits the rate exactly.
    queue_request({ClkW{1'b1}}, RateW'(RateMax));
    queue_request({ClkW{1'b1}}, '0);
    // Largest clock with a rate that only the 384fs mode gets within range of.
    queue_request({ClkW{1'b1}}, RateW'(174762));
    // Both modes exact for 44.1 kHz: the tie stays with 256fs.
    queue_request(ClkW'(67737600), RateW'(44100));
    // Only 384fs is exact for 48 kHz.
    queue_request(ClkW'(18432000), RateW'(48000));
    // Tiny clock: several dividers give the same quotient, the first wins.
    queue_request(ClkW'(768), '0);
    queue_request(ClkW'(768), RateW'(1));
    // Clocks just below the 256 and 384 boundaries and at 384.
    queue_request(ClkW'(255), RateW'(1));
    queue_request(ClkW'(383), RateW'(1));
    queue_request(ClkW'(384), RateW'(1));
    // Alternating bit patterns on both fields.
    queue_request(ClkW'(31'h5555_5555), RateW'(20'hAAAAA));
    queue_request(ClkW'(31'h2AAA_AAAA), RateW'(20'h55555));
    // Common codec clocks against common rates.
    queue_request(ClkW'(12288000), RateW'(8000));
    queue_request(ClkW'(11289600), RateW'(22050));
    queue_request(ClkW'(24576000), RateW'(96000));
    queue_request(ClkW'(133000000), RateW'(44100));
    wait_until_drained();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    // Between phases the sender waits until every result has come back.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 80; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 80; end
        default: begin send_gap_pct = 12; stall_pct = 12; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        kind = $urandom_range(0, 9);
        // Clocks are mostly spread over all magnitudes, some fully uniform.
        if (kind < 3) begin
          clk_v = ClkW'($urandom());
        end else begin
          clk_v = ClkW'($urandom() >> $urandom_range(1, 31));
        end
        if (kind < 2) begin
          target = longint'(RateW'($urandom()));
        end else begin
          // Aim near some divider of one base, then miss by a random amount
          // so errors land around zero, mid-range and the error limit.
          target = (kind[0] ? longint'(clk_v) / 384 : longint'(clk_v) / 256)
                   / $urandom_range(1, NumDividers);
          case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 8;
            2: span = 1000;
            default: span = 70000;
          endcase
          target = target + longint'($urandom_range(0, 2 * span)) - span;
          if (target < 0) target = 0;
          if (target > RateMax) target = RateMax;
        end
        queue_request(clk_v, RateW'(target));
      end
      wait_until_drained();
    end

    // Nothing is outstanding; give any stray result time to show up.
    stall_pct = 0;
    repeat (DrainCycles) @(negedge clk_i);
    if (predicted_settings.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", predicted_settings.size()));
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
